// ----- hdl/tled_pkg.sv -----
// Shared types and constants for the terminal line editor.
// No dependencies.
`default_nettype none
package tled_pkg;
   localparam int LINE_CAPACITY = 64;
   localparam int HISTORY_DEPTH = 8;
   localparam int LEN_W         = $clog2(LINE_CAPACITY);
   localparam int SLOT_W        = $clog2(HISTORY_DEPTH);
   localparam int USED_W        = $clog2(HISTORY_DEPTH + 1);
   localparam int HIST_AW       = SLOT_W + LEN_W;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] CH_ETX = 8'h03;
   localparam logic [7:0] CH_BS  = 8'h08;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_ESC = 8'h1B;
   localparam logic [7:0] CH_SP  = 8'h20;
   localparam logic [7:0] CH_DEL = 8'h7F;
   localparam logic [7:0] CH_LBR = 8'h5B;
   localparam logic [7:0] CH_UP  = 8'h41;
   localparam logic [7:0] CH_DN  = 8'h42;

   typedef enum logic [2:0] {
      EV_ECHO        = 3'd0,
      EV_ERASE       = 3'd1,
      EV_SUBMIT_CHAR = 3'd2,
      EV_SUBMIT_EMPTY= 3'd3,
      EV_CANCEL      = 3'd4,
      EV_REPL_CHAR   = 3'd5,
      EV_REPL_EMPTY  = 3'd6
   } event_type;

   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_ESC    = 2'd1,
      MODE_CSI    = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      CMD_NONE   = 3'd0,
      CMD_SUBMIT = 3'd1,
      CMD_ERASE  = 3'd2,
      CMD_CANCEL = 3'd3,
      CMD_APPEND = 3'd4,
      CMD_OLDER  = 3'd5,
      CMD_NEWER  = 3'd6
   } cmd_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] ch;
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE    = 3'd0,
      ST_ERASE   = 3'd1,
      ST_COPY    = 3'd2,
      ST_EMIT    = 3'd3,
      ST_SAVE    = 3'd4
   } state_type;
endpackage
`default_nettype wire

// ----- hdl/tled_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module tled_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ----- hdl/tled_front.sv -----
// Front end: escape parser, byte classification and a small command queue.
// Depends on tled_pkg.
`default_nettype none
module tled_front import tled_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_rx_byte,
   output logic            op_valid,
   input  wire logic       op_take,
   output op_type          op
);
   mode_type               mode_ff, mode_in;
   op_type                 q_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]    rd_ff, wr_ff;
   logic [QUEUE_AW:0]      cnt_ff;
   op_type                 dec;
   logic                   acc;
   logic                   push;

   assign req_stall = (cnt_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign acc       = req_valid && !req_stall;

   always_comb begin
      mode_in  = MODE_NORMAL;
      dec.cmd  = CMD_NONE;
      dec.ch   = req_rx_byte;
      case (mode_ff)
         MODE_ESC: begin
            mode_in = (req_rx_byte == CH_LBR) ? MODE_CSI : MODE_NORMAL;
         end
         MODE_CSI: begin
            if (req_rx_byte == CH_UP) dec.cmd = CMD_OLDER;
            else if (req_rx_byte == CH_DN) dec.cmd = CMD_NEWER;
         end
         default: begin
            if (req_rx_byte == CH_LF || req_rx_byte == CH_CR) dec.cmd = CMD_SUBMIT;
            else if (req_rx_byte == CH_BS || req_rx_byte == CH_DEL) dec.cmd = CMD_ERASE;
            else if (req_rx_byte == CH_ETX) dec.cmd = CMD_CANCEL;
            else if (req_rx_byte == CH_ESC) mode_in = MODE_ESC;
            else if (req_rx_byte >= CH_SP || req_rx_byte == CH_TAB) dec.cmd = CMD_APPEND;
         end
      endcase
   end

   assign push     = acc && (dec.cmd != CMD_NONE);
   assign op_valid = (cnt_ff != '0);
   assign op       = q_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= dec;
      end
      if (reset) begin
         mode_ff <= MODE_NORMAL;
         rd_ff   <= '0;
         wr_ff   <= '0;
         cnt_ff  <= '0;
      end else begin
         if (acc) mode_ff <= mode_in;
         if (push) wr_ff <= wr_ff + 1'b1;
         if (op_take) rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(op_take);
      end
   end
endmodule
`default_nettype wire

// ----- hdl/tled_back.sv -----
// Back end: line, history and saved-line memories and the event sequencer.
// Depends on tled_pkg and tled_ram.
`default_nettype none
module tled_back import tled_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             op_valid,
   output logic                  op_take,
   input  op_type                op,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [2:0]            rsp_event_res,
   output logic [7:0]            rsp_char_out,
   output logic [5:0]            rsp_char_index,
   output logic [5:0]            rsp_old_length,
   output logic [5:0]            rsp_new_length,
   output logic                  rsp_last
);
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(LINE_CAPACITY - 1);

   state_type            st_ff, st_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic [LEN_W-1:0]     sav_len_ff, sav_len_in;
   logic [LEN_W-1:0]     hl_ff [HISTORY_DEPTH];
   logic [USED_W-1:0]    used_ff, used_in;
   logic [SLOT_W-1:0]    next_ff, next_in;
   logic                 live_ff, live_in;
   logic [SLOT_W-1:0]    boff_ff, boff_in;
   logic [LEN_W-1:0]     i_ff, i_in;
   logic [LEN_W-1:0]     n_ff, n_in;
   logic [LEN_W-1:0]     oldl_ff, oldl_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic                 from_sav_ff, from_sav_in;
   logic                 rd_pend_ff, rd_pend_in;
   event_type            ev_ff, ev_in;

   logic                 ov_ff, ov_in;
   logic [2:0]           o_ev_ff, o_ev_in;
   logic [7:0]           o_ch_ff, o_ch_in;
   logic [5:0]           o_ix_ff, o_ix_in;
   logic [5:0]           o_ol_ff, o_ol_in;
   logic [5:0]           o_nl_ff, o_nl_in;
   logic                 o_la_ff, o_la_in;
   logic [LEN_W-1:0]     cap_ix_ff, cap_ix_in;
   logic                 cap_v_ff, cap_v_in;
   logic                 cap_last_ff, cap_last_in;

   logic                 ln_we, hs_we, sv_we;
   logic [LEN_W-1:0]     ln_wa, ln_ra, sv_wa, sv_ra;
   logic [7:0]           ln_wd, ln_rd, hs_wd, hs_rd, sv_wd, sv_rd;
   logic [HIST_AW-1:0]   hs_wa, hs_ra;
   logic                 hl_we;
   logic [SLOT_W-1:0]    hl_wa;
   logic [LEN_W-1:0]     hl_wd;
   logic                 out_free;

   tled_ram #(.WIDTH(8), .DEPTH(LINE_CAPACITY)) u_line (
      .clock, .wr_en(ln_we), .wr_addr(ln_wa), .wr_data(ln_wd),
      .rd_addr(ln_ra), .rd_data(ln_rd));
   tled_ram #(.WIDTH(8), .DEPTH(HISTORY_DEPTH * LINE_CAPACITY)) u_hist (
      .clock, .wr_en(hs_we), .wr_addr(hs_wa), .wr_data(hs_wd),
      .rd_addr(hs_ra), .rd_data(hs_rd));
   tled_ram #(.WIDTH(8), .DEPTH(LINE_CAPACITY)) u_save (
      .clock, .wr_en(sv_we), .wr_addr(sv_wa), .wr_data(sv_wd),
      .rd_addr(sv_ra), .rd_data(sv_rd));

   assign out_free       = !ov_ff || !rsp_stall;
   assign rsp_valid      = ov_ff;
   assign rsp_event_res  = o_ev_ff;
   assign rsp_char_out   = o_ch_ff;
   assign rsp_char_index = o_ix_ff;
   assign rsp_old_length = o_ol_ff;
   assign rsp_new_length = o_nl_ff;
   assign rsp_last       = o_la_ff;

   function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] nx,
                                                 input logic [SLOT_W-1:0] bo);
      slot_of = nx - 1'b1 - bo;
   endfunction

   // Pipeline: an address is issued together with cap_v, and the registered RAM data read at it forms the result.
   always_comb begin
      st_in = st_ff; len_in = len_ff; sav_len_in = sav_len_ff; used_in = used_ff;
      next_in = next_ff; live_in = live_ff; boff_in = boff_ff; i_in = i_ff;
      n_in = n_ff; oldl_in = oldl_ff; slot_in = slot_ff; from_sav_in = from_sav_ff;
      rd_pend_in = rd_pend_ff; ev_in = ev_ff;
      ov_in = ov_ff && rsp_stall;
      o_ev_in = o_ev_ff; o_ch_in = o_ch_ff; o_ix_in = o_ix_ff;
      o_ol_in = o_ol_ff; o_nl_in = o_nl_ff; o_la_in = o_la_ff;
      cap_ix_in = cap_ix_ff; cap_v_in = 1'b0; cap_last_in = cap_last_ff;
      op_take = 1'b0;
      ln_we = 1'b0; ln_wa = len_ff; ln_wd = op.ch; ln_ra = len_ff - 1'b1;
      hs_we = 1'b0; hs_wa = {next_ff, i_ff}; hs_wd = ln_rd;
      hs_ra = {slot_ff, i_ff};
      sv_we = 1'b0; sv_wa = i_ff; sv_wd = ln_rd; sv_ra = i_ff;
      hl_we = 1'b0; hl_wa = next_ff; hl_wd = len_ff;

      // result from data read last cycle
      if (cap_v_ff) begin
         ov_in   = 1'b1;
         o_ev_in = ev_ff;
         o_ix_in = 6'(cap_ix_ff);
         o_la_in = cap_last_ff;
         o_ol_in = 6'(oldl_ff);
         case (ev_ff)
            EV_ERASE: begin
               o_ch_in = ln_rd; o_nl_in = 6'(len_ff);
            end
            EV_SUBMIT_CHAR: begin
               o_ch_in = ln_rd; o_nl_in = '0;
            end
            default: begin
               o_ch_in = from_sav_ff ? sv_rd : hs_rd; o_nl_in = 6'(n_ff);
            end
         endcase
      end

      case (st_ff)
         ST_IDLE: begin
            if (op_valid && out_free && !cap_v_ff) begin
               op_take = 1'b1;
               case (op.cmd)
                  CMD_APPEND: begin
                     if (len_ff != MAX_LEN) begin
                        ln_we = 1'b1;
                        ov_in = 1'b1; o_ev_in = EV_ECHO; o_ch_in = op.ch;
                        o_ix_in = 6'(len_ff); o_ol_in = 6'(len_ff);
                        o_nl_in = 6'(len_ff + 1'b1); o_la_in = 1'b1;
                        len_in = len_ff + 1'b1;
                     end
                  end
                  CMD_ERASE: begin
                     if (len_ff != '0) begin
                        ev_in = EV_ERASE; oldl_in = len_ff;
                        len_in = len_ff - 1'b1; cap_ix_in = len_ff - 1'b1;
                        cap_last_in = 1'b1; cap_v_in = 1'b1;
                     end
                  end
                  CMD_CANCEL: begin
                     ov_in = 1'b1; o_ev_in = EV_CANCEL; o_ch_in = '0; o_ix_in = '0;
                     o_ol_in = 6'(len_ff); o_nl_in = '0; o_la_in = 1'b1;
                     len_in = '0; live_in = 1'b1;
                  end
                  CMD_SUBMIT: begin
                     live_in = 1'b1;
                     if (len_ff == '0) begin
                        ov_in = 1'b1; o_ev_in = EV_SUBMIT_EMPTY; o_ch_in = '0;
                        o_ix_in = '0; o_ol_in = '0; o_nl_in = '0; o_la_in = 1'b1;
                     end else begin
                        hl_we = 1'b1;
                        ev_in = EV_SUBMIT_CHAR; oldl_in = len_ff; n_in = len_ff;
                        slot_in = next_ff; i_in = '0; rd_pend_in = 1'b0;
                        len_in = '0; st_in = ST_COPY;
                        next_in = (next_ff == SLOT_W'(HISTORY_DEPTH - 1)) ? '0
                                  : next_ff + 1'b1;
                        if (used_ff != USED_W'(HISTORY_DEPTH)) used_in = used_ff + 1'b1;
                     end
                  end
                  CMD_OLDER: begin
                     if (used_ff != '0 &&
                         (live_ff || (USED_W'(boff_ff) + 1'b1) < used_ff)) begin
                        oldl_in = len_ff; from_sav_in = 1'b0; ev_in = EV_REPL_CHAR;
                        i_in = '0; rd_pend_in = 1'b0;
                        if (live_ff) begin
                           live_in = 1'b0; boff_in = '0; sav_len_in = len_ff;
                           slot_in = slot_of(next_ff, '0);
                           st_in = ST_SAVE;
                        end else begin
                           boff_in = boff_ff + 1'b1;
                           slot_in = slot_of(next_ff, boff_ff + 1'b1);
                           st_in = ST_EMIT;
                        end
                     end
                  end
                  CMD_NEWER: begin
                     if (!live_ff) begin
                        oldl_in = len_ff; ev_in = EV_REPL_CHAR;
                        i_in = '0; rd_pend_in = 1'b0;
                        if (boff_ff == '0) begin
                           live_in = 1'b1; from_sav_in = 1'b1;
                        end else begin
                           boff_in = boff_ff - 1'b1; from_sav_in = 1'b0;
                           slot_in = slot_of(next_ff, boff_ff - 1'b1);
                        end
                        st_in = ST_EMIT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SAVE: begin
            // copy line into saved store: read at i while writing the char read last cycle at i-1
            ln_ra = i_ff;
            sv_wa = i_ff - 1'b1;
            sv_we = rd_pend_ff;
            rd_pend_in = 1'b1;
            if (rd_pend_ff && (i_ff == sav_len_ff)) begin
               i_in = '0; rd_pend_in = 1'b0; st_in = ST_EMIT;
            end else if (i_ff == sav_len_ff) begin
               i_in = '0; rd_pend_in = 1'b0; st_in = ST_EMIT;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         ST_COPY: begin
            // submit: stream line chars out and into history slot
            ln_ra = i_ff;
            hs_wa = {slot_ff, cap_ix_ff};
            hs_we = cap_v_ff;
            if (i_ff == n_ff) begin
               if (!cap_v_ff) st_in = ST_IDLE;
            end else if (!cap_v_ff && out_free) begin
               cap_v_in = 1'b1; cap_ix_in = i_ff;
               cap_last_in = (i_ff + 1'b1 == n_ff);
               i_in = i_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (i_ff == '0 && !rd_pend_ff) begin
               n_in = from_sav_ff ? sav_len_ff : hl_ff[slot_ff];
               rd_pend_in = 1'b1;
            end else if (n_ff == '0) begin
               len_in = '0;
               if (out_free && !cap_v_ff) begin
                  ov_in = 1'b1; o_ev_in = EV_REPL_EMPTY; o_ch_in = '0;
                  o_ix_in = '0; o_ol_in = 6'(oldl_ff); o_nl_in = '0; o_la_in = 1'b1;
                  rd_pend_in = 1'b0; st_in = ST_IDLE;
               end
            end else begin
               len_in = n_ff;
               sv_ra = i_ff; hs_ra = {slot_ff, i_ff};
               ln_we = 1'b0;
               if (i_ff == n_ff) begin
                  if (!cap_v_ff) begin
                     rd_pend_in = 1'b0; st_in = ST_IDLE;
                  end
               end else if (!cap_v_ff && out_free) begin
                  cap_v_in = 1'b1; cap_ix_in = i_ff;
                  cap_last_in = (i_ff + 1'b1 == n_ff);
                  i_in = i_ff + 1'b1;
               end
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase

      // write replacement chars into line store as they are read
      if (cap_v_ff && ev_ff == EV_REPL_CHAR) begin
         ln_we = 1'b1; ln_wa = cap_ix_ff;
         ln_wd = from_sav_ff ? sv_rd : hs_rd;
      end
   end

   always_ff @(posedge clock) begin
      if (hl_we) hl_ff[hl_wa] <= hl_wd;
      o_ev_ff <= o_ev_in; o_ch_ff <= o_ch_in; o_ix_ff <= o_ix_in;
      o_ol_ff <= o_ol_in; o_nl_ff <= o_nl_in; o_la_ff <= o_la_in;
      i_ff <= i_in; n_ff <= n_in; oldl_ff <= oldl_in; slot_ff <= slot_in;
      from_sav_ff <= from_sav_in; ev_ff <= ev_in; cap_ix_ff <= cap_ix_in;
      cap_last_ff <= cap_last_in;
      if (reset) begin
         st_ff <= ST_IDLE; len_ff <= '0; sav_len_ff <= '0; used_ff <= '0;
         next_ff <= '0; live_ff <= 1'b1; boff_ff <= '0; rd_pend_ff <= 1'b0;
         ov_ff <= 1'b0; cap_v_ff <= 1'b0;
      end else begin
         st_ff <= st_in; len_ff <= len_in; sav_len_ff <= sav_len_in;
         used_ff <= used_in; next_ff <= next_in; live_ff <= live_in;
         boff_ff <= boff_in; rd_pend_ff <= rd_pend_in;
         ov_ff <= ov_in; cap_v_ff <= cap_v_in;
      end
   end
endmodule
`default_nettype wire

// ----- hdl/terminal_line_editor_with_history_unit.sv -----
// Terminal line editor with command history: top level.
// Echo, cancel and empty submit events come straight from the command; erase first reads the line memory.
// Submit and recall stream the line one character at a time, up to 63 characters;
// a first recall first copies the live line into the saved store.
// A new character is read only once the last one is out and the output is not stalled.
// Reset (synchronous) empties line and history; memories keep no reset value.
`default_nettype none
module terminal_line_editor_with_history_unit import tled_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [2:0]      rsp_event_res,
   output logic [7:0]      rsp_char_out,
   output logic [5:0]      rsp_char_index,
   output logic [5:0]      rsp_old_length,
   output logic [5:0]      rsp_new_length,
   output logic            rsp_last
);
   logic   op_valid, op_take;
   op_type op;

   tled_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_rx_byte,
      .op_valid, .op_take, .op);

   tled_back u_back (
      .clock, .reset, .op_valid, .op_take, .op,
      .rsp_valid, .rsp_stall, .rsp_event_res, .rsp_char_out, .rsp_char_index,
      .rsp_old_length, .rsp_new_length, .rsp_last);

`ifndef SYNTH
   a_take_needs_op: assert property (@(posedge clock) disable iff (reset)
      op_take |-> op_valid) else $error("command taken from empty queue");
   a_hold_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_char_out))
      else $error("stalled result changed");
   a_event_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_event_res != 3'd7) else $error("bad event code");
`endif
endmodule
`default_nettype wire
